### rtl/gfql_pkg.sv
// Package for the group-favoring queued lock arbiter.
// Holds command and result codes, controller states, datapath operations.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gfql_pkg;

    localparam int GFQL_NUM_LOCKS   = 16;
    localparam int GFQL_QUEUE_DEPTH = 16;
    localparam logic [6:0] FAVOR_MAX = 7'd100;

    localparam logic [1:0] CMD_CREATE  = 2'd0;
    localparam logic [1:0] CMD_DESTROY = 2'd1;
    localparam logic [1:0] CMD_ACQUIRE = 2'd2;
    localparam logic [1:0] CMD_RELEASE = 2'd3;

    localparam logic [2:0] KIND_CREATE  = 3'd0;
    localparam logic [2:0] KIND_DESTROY = 3'd1;
    localparam logic [2:0] KIND_QUEUED  = 3'd2;
    localparam logic [2:0] KIND_GRANT   = 3'd3;
    localparam logic [2:0] KIND_RELEASE = 3'd4;
    localparam logic [2:0] KIND_FAILED  = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_CREATE, ST_BAD, ST_DES_RD, ST_DES_EMIT, ST_DES_DONE,
        ST_ACQ_ERR, ST_ACQ_PUSH, ST_GR_RD, ST_GRANT, ST_REL_ERR, ST_REL_EMIT,
        ST_SR_RD, ST_SR_CHK, ST_SH_RD, ST_SH_WR, ST_SH_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CREATE, OP_BAD, OP_RD_IDX, OP_DES_EMIT, OP_DES_DONE,
        OP_ACQ_ERR, OP_ACQ_PUSH, OP_RD_HEAD, OP_GRANT, OP_REL_ERR, OP_REL_EMIT,
        OP_SRCH_CHK, OP_SH_RD, OP_SH_WR, OP_SH_FIN
    } t_dp_op;

    typedef struct packed {
        logic [1:0] cmd;
        logic       bad;
        logic       full;
        logic       held;
        logic       count_zero;
        logic       i_last;
        logic       i_one;
        logic       match;
        logic       shift_ok;
        logic       out_free;
    } t_dp_status;

endpackage
`default_nettype wire

### rtl/gfql_in_if.sv
// Request channel of the lock arbiter: valid/ready plus command payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface gfql_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [3:0] lock_index;
    logic [6:0] favor_percent;
    logic [9:0] requester_pid;
    logic [7:0] requester_gid;
    logic [6:0] random_percent;

    modport source (output valid, cmd, lock_index, favor_percent, requester_pid,
                    requester_gid, random_percent, input ready);
    modport sink   (input valid, cmd, lock_index, favor_percent, requester_pid,
                    requester_gid, random_percent, output ready);
endinterface
`default_nettype wire

### rtl/gfql_out_if.sv
// Response channel of the lock arbiter: valid/ready plus result payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface gfql_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic       status_error;
    logic [3:0] lock_number;
    logic [9:0] target_pid;
    logic       last;

    modport source (output valid, kind, status_error, lock_number, target_pid, last,
                    input ready);
    modport sink   (input valid, kind, status_error, lock_number, target_pid, last,
                    output ready);
endinterface
`default_nettype wire

### rtl/gfql_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gfql_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### rtl/gfql_datapath.sv
// Datapath of the lock arbiter: per-lock state, wait-ring RAM, result register.
// Depends on gfql_pkg and gfql_ram.
`timescale 1ns / 1ps
`default_nettype none
module gfql_datapath #(
    parameter int NUM_LOCKS   = gfql_pkg::GFQL_NUM_LOCKS,
    parameter int QUEUE_DEPTH = gfql_pkg::GFQL_QUEUE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire gfql_pkg::t_dp_op     i_op,
    output gfql_pkg::t_dp_status      o_status,
    input  wire logic [1:0]           i_cmd,
    input  wire logic [3:0]           i_lock_index,
    input  wire logic [6:0]           i_favor_percent,
    input  wire logic [9:0]           i_requester_pid,
    input  wire logic [7:0]           i_requester_gid,
    input  wire logic [6:0]           i_random_percent,
    output logic                      o_valid,
    input  wire logic                 i_out_ready,
    output logic [2:0]                o_kind,
    output logic                      o_status_error,
    output logic [3:0]                o_lock_number,
    output logic [9:0]                o_target_pid,
    output logic                      o_last
);
    import gfql_pkg::*;

    localparam int LK_W  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int QP_W  = $clog2(QUEUE_DEPTH);
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH = NUM_LOCKS * QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = 18;

    logic [1:0]      r_cmd;
    logic [3:0]      r_lk;
    logic [6:0]      r_fav;
    logic [9:0]      r_pid;
    logic [7:0]      r_gid;
    logic [6:0]      r_rnd;
    logic [QC_W-1:0] r_i;
    logic [DW-1:0]   r_save;

    logic [NUM_LOCKS-1:0] r_active;
    logic [NUM_LOCKS-1:0] r_held;
    logic [6:0]           r_favor [NUM_LOCKS];
    logic [7:0]           r_owner [NUM_LOCKS];
    logic [QP_W-1:0]      r_head  [NUM_LOCKS];
    logic [QC_W-1:0]      r_count [NUM_LOCKS];

    logic [LK_W-1:0] lk_sel;
    logic [LK_W-1:0] free_idx;
    logic            free_any;
    logic            create_ok;
    logic [QP_W-1:0] cur_head;
    logic [QC_W-1:0] cur_count;
    logic [QP_W-1:0] head_inc;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [DW-1:0]   ram_wdata, ram_rdata;
    logic [QC_W-1:0] rd_off, wr_off;

    logic            e_valid, e_err, e_last;
    logic [2:0]      e_kind;
    logic [3:0]      e_lk;
    logic [9:0]      e_pid;

    function automatic logic [QP_W-1:0] wrap_pos(input logic [QP_W-1:0] h,
                                                 input logic [QC_W-1:0] off);
        logic [QC_W:0] s;
        s = (QC_W+1)'(h) + (QC_W+1)'(off);
        if (s >= (QC_W+1)'(QUEUE_DEPTH)) begin
            s = s - (QC_W+1)'(QUEUE_DEPTH);
        end
        return QP_W'(s);
    endfunction

    function automatic logic [AW-1:0] slot(input logic [LK_W-1:0] lk,
                                           input logic [QP_W-1:0] pos);
        return AW'(AW'(lk) * AW'(QUEUE_DEPTH)) + AW'(pos);
    endfunction

    assign lk_sel    = LK_W'(r_lk);
    assign cur_head  = r_head[lk_sel];
    assign cur_count = r_count[lk_sel];
    assign head_inc  = ((QC_W+1)'(cur_head) + 1'b1 == (QC_W+1)'(QUEUE_DEPTH)) ?
                       '0 : cur_head + 1'b1;

    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int k = NUM_LOCKS - 1; k >= 0; k--) begin
            if (!r_active[k]) begin
                free_idx = LK_W'(k);
                free_any = 1'b1;
            end
        end
    end
    assign create_ok = (r_fav <= FAVOR_MAX) && free_any;

    always_comb begin
        o_status.cmd        = r_cmd;
        o_status.bad        = ({3'b000, r_lk} >= 7'(NUM_LOCKS)) || !r_active[lk_sel];
        o_status.full       = cur_count == QC_W'(QUEUE_DEPTH);
        o_status.held       = r_held[lk_sel];
        o_status.count_zero = cur_count == '0;
        o_status.i_last     = (QC_W+1)'(r_i) + 1'b1 == (QC_W+1)'(cur_count);
        o_status.i_one      = r_i == QC_W'(1);
        o_status.match      = ram_rdata[7:0] == r_owner[lk_sel];
        o_status.shift_ok   = (r_i != '0) && (r_rnd < r_favor[lk_sel]);
        o_status.out_free   = !o_valid || i_out_ready;
    end

    // wait-ring RAM addressing
    always_comb begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        rd_off    = '0;
        wr_off    = '0;
        ram_wdata = ram_rdata;
        case (i_op)
            OP_RD_IDX: begin
                ram_re = 1'b1;
                rd_off = r_i;
            end
            OP_RD_HEAD: begin
                ram_re = 1'b1;
            end
            OP_SH_RD: begin
                ram_re = 1'b1;
                rd_off = r_i - 1'b1;
            end
            OP_ACQ_PUSH: begin
                ram_we    = 1'b1;
                wr_off    = cur_count;
                ram_wdata = {r_pid, r_gid};
            end
            OP_SH_WR: begin
                ram_we = 1'b1;
                wr_off = r_i;
            end
            OP_SH_FIN: begin
                ram_we    = 1'b1;
                ram_wdata = r_save;
            end
            default: begin
            end
        endcase
        ram_raddr = slot(lk_sel, wrap_pos(cur_head, rd_off));
        ram_waddr = slot(lk_sel, wrap_pos(cur_head, wr_off));
    end

    gfql_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result selection
    always_comb begin
        e_valid = 1'b1;
        e_kind  = KIND_RELEASE;
        e_err   = 1'b0;
        e_lk    = r_lk;
        e_pid   = '0;
        e_last  = 1'b1;
        case (i_op)
            OP_CREATE: begin
                e_kind = KIND_CREATE;
                e_err  = !create_ok;
                e_lk   = create_ok ? 4'(free_idx) : 4'd0;
            end
            OP_BAD: begin
                e_err = 1'b1;
                case (r_cmd)
                    CMD_DESTROY: e_kind = KIND_DESTROY;
                    CMD_ACQUIRE: begin
                        e_kind = KIND_QUEUED;
                        e_pid  = r_pid;
                    end
                    default:     e_kind = KIND_RELEASE;
                endcase
            end
            OP_DES_EMIT: begin
                e_kind = KIND_FAILED;
                e_err  = 1'b1;
                e_pid  = ram_rdata[17:8];
                e_last = 1'b0;
            end
            OP_DES_DONE: e_kind = KIND_DESTROY;
            OP_ACQ_ERR: begin
                e_kind = KIND_QUEUED;
                e_err  = 1'b1;
                e_pid  = r_pid;
            end
            OP_ACQ_PUSH: begin
                e_kind = KIND_QUEUED;
                e_pid  = r_pid;
                e_last = r_held[lk_sel];
            end
            OP_GRANT: begin
                e_kind = KIND_GRANT;
                e_pid  = ram_rdata[17:8];
            end
            OP_REL_ERR: e_err = 1'b1;
            OP_REL_EMIT: e_last = cur_count == '0;
            default: e_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (e_valid) begin
            o_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_valid) begin
            o_kind         <= e_kind;
            o_status_error <= e_err;
            o_lock_number  <= e_lk;
            o_target_pid   <= e_pid;
            o_last         <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD) begin
            r_cmd <= i_cmd;
            r_lk  <= i_lock_index;
            r_fav <= i_favor_percent;
            r_pid <= i_requester_pid;
            r_gid <= i_requester_gid;
            r_rnd <= i_random_percent;
        end
        if (i_op == OP_SRCH_CHK && o_status.match) begin
            r_save <= ram_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i      <= '0;
            r_active <= '0;
            r_held   <= '0;
            for (int k = 0; k < NUM_LOCKS; k++) begin
                r_favor[k] <= '0;
                r_owner[k] <= '0;
                r_head[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            case (i_op)
                OP_LOAD: r_i <= '0;
                OP_CREATE: begin
                    if (create_ok) begin
                        r_active[free_idx] <= 1'b1;
                        r_held[free_idx]   <= 1'b0;
                        r_favor[free_idx]  <= r_fav;
                        r_owner[free_idx]  <= '0;
                        r_head[free_idx]   <= '0;
                        r_count[free_idx]  <= '0;
                    end
                end
                OP_DES_EMIT: r_i <= r_i + 1'b1;
                OP_DES_DONE: begin
                    r_active[lk_sel] <= 1'b0;
                    r_held[lk_sel]   <= 1'b0;
                    r_head[lk_sel]   <= '0;
                    r_count[lk_sel]  <= '0;
                end
                OP_ACQ_PUSH: r_count[lk_sel] <= cur_count + 1'b1;
                OP_GRANT: begin
                    r_owner[lk_sel] <= ram_rdata[7:0];
                    r_held[lk_sel]  <= 1'b1;
                    r_head[lk_sel]  <= head_inc;
                    r_count[lk_sel] <= cur_count - 1'b1;
                end
                OP_REL_EMIT: begin
                    r_held[lk_sel] <= 1'b0;
                    r_i            <= '0;
                end
                OP_SRCH_CHK: begin
                    if (!o_status.match) begin
                        r_i <= r_i + 1'b1;
                    end
                end
                OP_SH_WR: r_i <= r_i - 1'b1;
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/gfql_controller.sv
// Controller state machine of the lock arbiter; sequences datapath operations.
// Depends on gfql_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gfql_controller (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire gfql_pkg::t_dp_status i_status,
    output gfql_pkg::t_dp_op          o_op
);
    import gfql_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_status.cmd == CMD_CREATE) begin
                    n_state = ST_CREATE;
                end else if (i_status.bad) begin
                    n_state = ST_BAD;
                end else if (i_status.cmd == CMD_DESTROY) begin
                    n_state = i_status.count_zero ? ST_DES_DONE : ST_DES_RD;
                end else if (i_status.cmd == CMD_ACQUIRE) begin
                    n_state = i_status.full ? ST_ACQ_ERR : ST_ACQ_PUSH;
                end else begin
                    n_state = i_status.held ? ST_REL_EMIT : ST_REL_ERR;
                end
            end
            ST_CREATE: begin
                if (i_status.out_free) begin
                    o_op    = OP_CREATE;
                    n_state = ST_IDLE;
                end
            end
            ST_BAD: begin
                if (i_status.out_free) begin
                    o_op    = OP_BAD;
                    n_state = ST_IDLE;
                end
            end
            ST_DES_RD: begin
                o_op    = OP_RD_IDX;
                n_state = ST_DES_EMIT;
            end
            ST_DES_EMIT: begin
                if (i_status.out_free) begin
                    o_op    = OP_DES_EMIT;
                    n_state = i_status.i_last ? ST_DES_DONE : ST_DES_RD;
                end
            end
            ST_DES_DONE: begin
                if (i_status.out_free) begin
                    o_op    = OP_DES_DONE;
                    n_state = ST_IDLE;
                end
            end
            ST_ACQ_ERR: begin
                if (i_status.out_free) begin
                    o_op    = OP_ACQ_ERR;
                    n_state = ST_IDLE;
                end
            end
            ST_ACQ_PUSH: begin
                if (i_status.out_free) begin
                    o_op    = OP_ACQ_PUSH;
                    n_state = i_status.held ? ST_IDLE : ST_GR_RD;
                end
            end
            ST_GR_RD: begin
                o_op    = OP_RD_HEAD;
                n_state = ST_GRANT;
            end
            ST_GRANT: begin
                if (i_status.out_free) begin
                    o_op    = OP_GRANT;
                    n_state = ST_IDLE;
                end
            end
            ST_REL_ERR: begin
                if (i_status.out_free) begin
                    o_op    = OP_REL_ERR;
                    n_state = ST_IDLE;
                end
            end
            ST_REL_EMIT: begin
                if (i_status.out_free) begin
                    o_op    = OP_REL_EMIT;
                    n_state = i_status.count_zero ? ST_IDLE : ST_SR_RD;
                end
            end
            ST_SR_RD: begin
                o_op    = OP_RD_IDX;
                n_state = ST_SR_CHK;
            end
            ST_SR_CHK: begin
                o_op = OP_SRCH_CHK;
                if (i_status.match) begin
                    n_state = i_status.shift_ok ? ST_SH_RD : ST_GR_RD;
                end else begin
                    n_state = i_status.i_last ? ST_GR_RD : ST_SR_RD;
                end
            end
            ST_SH_RD: begin
                o_op    = OP_SH_RD;
                n_state = ST_SH_WR;
            end
            ST_SH_WR: begin
                o_op    = OP_SH_WR;
                n_state = i_status.i_one ? ST_SH_FIN : ST_SH_RD;
            end
            ST_SH_FIN: begin
                o_op    = OP_SH_FIN;
                n_state = ST_GR_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### rtl/group_favoring_queued_lock_arbiter.sv
// Top level of the group-favoring queued lock arbiter.
// Depends on gfql_pkg, gfql_in_if, gfql_out_if, gfql_controller, gfql_datapath.
//
// One command transaction is taken at a time and turned into one or more
// result transactions, the final one marked by last. The next command is taken
// as soon as the final result sits in the output register. Destroy reports each
// waiter as failed before the destroy result; an acquire of a free lock is
// followed by a grant; release with waiters searches the wait ring for a
// waiter of the releasing owner's group and, when favoring, shifts it to the
// head before the head is granted. The RAM needs no clearing pass after reset.
// Each result waits while the output register is still occupied.
`timescale 1ns / 1ps
`default_nettype none
module group_favoring_queued_lock_arbiter #(
    parameter int NUM_LOCKS   = gfql_pkg::GFQL_NUM_LOCKS,
    parameter int QUEUE_DEPTH = gfql_pkg::GFQL_QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gfql_in_if.sink    i_req,
    gfql_out_if.source o_rsp
);
    import gfql_pkg::*;

    t_dp_op     dp_op;
    t_dp_status dp_status;

    gfql_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (dp_status),
        .o_op       (dp_op)
    );

    gfql_datapath #(
        .NUM_LOCKS   (NUM_LOCKS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (dp_op),
        .o_status         (dp_status),
        .i_cmd            (i_req.cmd),
        .i_lock_index     (i_req.lock_index),
        .i_favor_percent  (i_req.favor_percent),
        .i_requester_pid  (i_req.requester_pid),
        .i_requester_gid  (i_req.requester_gid),
        .i_random_percent (i_req.random_percent),
        .o_valid          (o_rsp.valid),
        .i_out_ready      (o_rsp.ready),
        .o_kind           (o_rsp.kind),
        .o_status_error   (o_rsp.status_error),
        .o_lock_number    (o_rsp.lock_number),
        .o_target_pid     (o_rsp.target_pid),
        .o_last           (o_rsp.last)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("command taken while another is in progress");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_op == OP_CREATE || dp_op == OP_BAD || dp_op == OP_DES_EMIT ||
         dp_op == OP_DES_DONE || dp_op == OP_ACQ_ERR || dp_op == OP_ACQ_PUSH ||
         dp_op == OP_GRANT || dp_op == OP_REL_ERR || dp_op == OP_REL_EMIT)
        |-> dp_status.out_free)
        else $error("result issued while output register is occupied");

    a_grant_needs_waiter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_op == OP_RD_HEAD |-> !dp_status.count_zero)
        else $error("grant from an empty wait ring");
`endif
endmodule
`default_nettype wire
